FILE: hw/rtl/int_to_radix_ascii_macros.svh
// Assertion macros for the integer to ASCII converter.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef INT_TO_RADIX_ASCII_MACROS_SVH
`define INT_TO_RADIX_ASCII_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ITRA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("int_to_radix_ascii: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ITRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("int_to_radix_ascii: next-cycle check failed");

`endif

FILE: hw/rtl/itra_pkg.sv
// Shared types, constants and functions for the integer to ASCII converter.
// No dependencies.
package itra_pkg;

    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_MAX_RADIX = 36;
    localparam int RADIX_W       = 6;
    localparam int CHAR_W        = 8;
    localparam int LEN_W         = 6;
    localparam int STEP_BITS     = 8;
    localparam int OUT_TDATA_W   = ((CHAR_W + LEN_W + 7) / 8) * 8;

    localparam logic [RADIX_W-1:0] MIN_RADIX  = 6'd2;
    localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0]  CHAR_NONE  = 8'h00;

    typedef struct packed {
        logic               start;
        logic [RADIX_W-1:0] divisor;
    } t_div_req;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < DEC_DIGITS) begin
            digit_char = CHAR_ZERO + d_ext;
        end else begin
            digit_char = CHAR_A + d_ext - CHAR_W'(DEC_DIGITS);
        end
    endfunction

endpackage

FILE: hw/rtl/itra_div.sv
// Iterative divider: WORD_BITS dividend by a 6-bit divisor, STEP_BITS
// quotient bits per cycle. Depends on itra_pkg.
module itra_div #(
    parameter int WORD_BITS = itra_pkg::DEF_WORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  itra_pkg::t_div_req           i_req,
    input  logic [WORD_BITS-1:0]         i_dividend,
    output logic                         o_done,
    output logic [WORD_BITS-1:0]         o_quot,
    output logic [itra_pkg::RADIX_W-1:0] o_rem
);
    import itra_pkg::*;

    localparam int PASSES = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W  = PASSES * STEP_BITS;
    localparam int PASS_W = $clog2(PASSES + 1);

    logic                r_busy;
    logic                r_done;
    logic [PASS_W-1:0]   r_pass;
    logic [PAD_W-1:0]    r_shift;
    logic [RADIX_W-1:0]  r_rem;
    logic [RADIX_W-1:0]  r_div;
    logic [PAD_W-1:0]    n_shift;
    logic [RADIX_W-1:0]  n_rem;

    always_comb begin
        logic [RADIX_W:0] part;
        n_shift = r_shift;
        n_rem   = r_rem;
        for (int i = 0; i < STEP_BITS; i++) begin
            part    = {n_rem, n_shift[PAD_W-1]};
            n_shift = {n_shift[PAD_W-2:0], 1'b0};
            if (part >= {1'b0, r_div}) begin
                part       = part - {1'b0, r_div};
                n_shift[0] = 1'b1;
            end
            n_rem = part[RADIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pass <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_pass  <= '0;
                r_shift <= PAD_W'(i_dividend);
                r_rem   <= '0;
                r_div   <= i_req.divisor;
            end else if (r_busy) begin
                r_shift <= n_shift;
                r_rem   <= n_rem;
                r_pass  <= r_pass + 1'b1;
                if (r_pass == PASS_W'(PASSES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_shift[WORD_BITS-1:0];
    assign o_rem  = r_rem;

endmodule

FILE: hw/rtl/int_to_radix_ascii.sv
// Integer to ASCII text in base 2 to MAX_RADIX, most significant character first.
// Depends on itra_pkg, itra_div and int_to_radix_ascii_macros.svh.
// Each digit is the remainder of one division in the shared divider; then the sign character
// is sent, then each digit character goes through S_READ, S_LOAD and S_SEND, which waits on output stalls.
// Throughput: one item at a time; ready again the cycle after the last character is taken.
// Error result appears in the cycle after accept. Synchronous active-low reset clears control.
module int_to_radix_ascii #(
    parameter int WORD_BITS = itra_pkg::DEF_WORD_BITS,
    parameter int MAX_RADIX = itra_pkg::DEF_MAX_RADIX
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   s_axis_tvalid,
    output logic                                                   s_axis_tready,
    // value [WORD_BITS-1:0], radix [WORD_BITS+5:WORD_BITS], zero pad
    input  logic [((WORD_BITS + itra_pkg::RADIX_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                                   m_axis_tvalid,
    input  logic                                                   m_axis_tready,
    // character [7:0], length [13:8], zero pad
    output logic [itra_pkg::OUT_TDATA_W-1:0]                       m_axis_tdata,
    output logic                                                   m_axis_tlast,
    // error [0]
    output logic [0:0]                                             m_axis_tuser
);
    import itra_pkg::*;

    `include "int_to_radix_ascii_macros.svh"

    localparam int ADDR_W = $clog2(WORD_BITS);
    localparam int CNT_W  = $clog2(WORD_BITS + 1);
    localparam int TOT_W  = CNT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_LOAD,
        S_SEND
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [ADDR_W-1:0]   r_idx;
    logic                r_neg;
    logic [RADIX_W-1:0]  r_radix;
    logic [RADIX_W-1:0]  r_rdata;
    logic                r_tvalid;
    logic [CHAR_W-1:0]   r_char;
    logic [LEN_W-1:0]    r_len;
    logic                r_last;
    logic                r_err;
    logic [RADIX_W-1:0]  r_mem [WORD_BITS];

    logic [WORD_BITS-1:0]     w_val;
    logic [RADIX_W-1:0]       w_radix;
    logic                     w_accept;
    logic                     w_radix_ok;
    logic [WORD_BITS-1:0]     w_mag;
    t_div_req                 w_req;
    logic [WORD_BITS-1:0]     w_dividend;
    logic                     w_done;
    logic [WORD_BITS-1:0]     w_quot;
    logic [RADIX_W-1:0]       w_rem;
    logic [TOT_W-1:0]         w_total;
    logic [TOT_W+LEN_W-1:0]   w_tot_ext;
    logic [LEN_W-1:0]         w_length;

    assign w_val      = s_axis_tdata[WORD_BITS-1:0];
    assign w_radix    = s_axis_tdata[WORD_BITS +: RADIX_W];
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_radix_ok = (w_radix >= MIN_RADIX) && (w_radix <= RADIX_W'(MAX_RADIX));
    assign w_mag      = w_val[WORD_BITS-1] ? -w_val : w_val;

    assign w_req.start   = (w_accept && w_radix_ok)
                         || (r_state == S_DIV && w_done && w_quot != '0);
    assign w_req.divisor = (r_state == S_IDLE) ? w_radix : r_radix;
    assign w_dividend    = (r_state == S_IDLE) ? w_mag : w_quot;

    itra_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_dividend (w_dividend),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_total   = TOT_W'(r_cnt) + TOT_W'(r_neg);
    assign w_tot_ext = (TOT_W + LEN_W)'(w_total);
    assign w_length  = w_tot_ext[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && w_done) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= w_rem;
        end
        if (r_state == S_READ) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tvalid <= 1'b0;
            r_cnt    <= '0;
            r_neg    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_radix_ok) begin
                            r_neg   <= w_val[WORD_BITS-1];
                            r_radix <= w_radix;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_char   <= CHAR_NONE;
                            r_len    <= '0;
                            r_last   <= 1'b1;
                            r_err    <= 1'b1;
                            r_tvalid <= 1'b1;
                            r_state  <= S_SEND;
                        end
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (w_quot == '0) begin
                            r_idx <= r_cnt[ADDR_W-1:0];
                            if (r_neg) begin
                                r_char   <= CHAR_MINUS;
                                r_len    <= '0;
                                r_last   <= 1'b0;
                                r_err    <= 1'b0;
                                r_tvalid <= 1'b1;
                                r_state  <= S_SEND;
                            end else begin
                                r_state <= S_READ;
                            end
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_char   <= digit_char(r_rdata);
                    r_err    <= 1'b0;
                    r_tvalid <= 1'b1;
                    r_state  <= S_SEND;
                    if (r_idx == '0) begin
                        r_last <= 1'b1;
                        r_len  <= w_length;
                    end else begin
                        r_last <= 1'b0;
                        r_len  <= '0;
                        r_idx  <= r_idx - 1'b1;
                    end
                end
                S_SEND: begin
                    if (m_axis_tready) begin
                        r_tvalid <= 1'b0;
                        r_state  <= r_last ? S_IDLE : S_READ;
                    end
                end
                default: begin
                    r_tvalid <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready   = (r_state == S_IDLE);
    assign m_axis_tvalid   = r_tvalid;
    assign m_axis_tdata    = OUT_TDATA_W'({r_len, r_char});
    assign m_axis_tlast    = r_last;
    assign m_axis_tuser[0] = r_err;

    `ITRA_ASSERT_NOW(a_ready_no_pending, s_axis_tready, !m_axis_tvalid)
    `ITRA_ASSERT_NOW(a_error_shape, m_axis_tvalid && m_axis_tuser[0],
                     m_axis_tlast && r_char == CHAR_NONE && r_len == '0)
    `ITRA_ASSERT_NOW(a_mid_len_zero, m_axis_tvalid && !m_axis_tlast, r_len == '0)
    `ITRA_ASSERT_NOW(a_count_bound, 1'b1, r_cnt <= CNT_W'(WORD_BITS))
    `ITRA_ASSERT_NEXT(a_bad_radix_err, w_accept && !w_radix_ok,
                      m_axis_tvalid && m_axis_tuser[0])

endmodule
